>>> rtl/ttsb_pkg.sv
`default_nettype none

package ttsb_pkg;

  // store geometry
  localparam int LINES  = 200;
  localparam int WIDTH  = 80;
  localparam int HEIGHT = 25;

  localparam int ROW_W  = $clog2(LINES);
  localparam int LINE_W = $clog2(LINES + 1);
  localparam int COL_W  = $clog2(WIDTH);
  localparam int VSUM_W = $clog2(LINES + HEIGHT);
  localparam int RSUM_W = $clog2(LINES + 32);
  localparam int DIFF_W = (ROW_W > 8) ? ROW_W : 8;
  localparam int DEPTH  = LINES * WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [7:0] CH_NEWLINE    = 8'd10;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] COLOR_DEFAULT = 8'h07;

  typedef enum logic [2:0] {
    CMD_PUT   = 3'd0,
    CMD_BKSP  = 3'd1,
    CMD_UP    = 3'd2,
    CMD_DOWN  = 3'd3,
    CMD_CLEAR = 3'd4,
    CMD_READ  = 3'd5
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FILL,
    ST_SCROLL
  } ctrl_state_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [4:0] view_row;
    logic [6:0] view_col;
  } cmd_t;

  typedef struct packed {
    logic [7:0] cursor_screen_row;
    logic [6:0] cursor_column;
    logic [7:0] view_top;
    logic [7:0] lines_used;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
  } rsp_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] color;
  } cell_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    cell_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

>>> rtl/ttsb_cell_ram.sv
`default_nettype none

module ttsb_cell_ram (
  input  logic                clk,
  input  ttsb_pkg::ram_req_t  req,
  output ttsb_pkg::cell_t     rdata
);
  import ttsb_pkg::*;

  cell_t mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ttsb_ctrl.sv
`default_nettype none

module ttsb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         text_color,
  input  logic               cmd_valid,
  input  ttsb_pkg::cmd_t     cmd,
  output logic               cmd_stall,
  input  logic               rsp_free,
  output logic               done,
  output ttsb_pkg::rsp_t     rsp_next,
  output ttsb_pkg::ram_req_t ram_req,
  input  ttsb_pkg::cell_t    ram_rdata
);
  import ttsb_pkg::*;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                input logic [ROW_W-1:0] line);
    logic [ROW_W:0] s;
    s = {1'b0, base} + {1'b0, line};
    if (s >= (ROW_W+1)'(LINES)) begin
      s = s - (ROW_W+1)'(LINES);
    end
    return ROW_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] row);
    return ADDR_W'(row * WIDTH);
  endfunction

  ctrl_state_t state, state_next;
  logic        pend;
  cmd_t        item;

  logic [ROW_W-1:0]  cursor_line;
  logic [COL_W-1:0]  cursor_x;
  logic [ROW_W-1:0]  top_line;
  logic [LINE_W-1:0] total_lines;
  logic [ROW_W-1:0]  ring_base;
  logic [7:0]        blank_color;
  logic [LINES-1:0]  written;

  logic [ADDR_W-1:0] fill_addr;
  logic [COL_W-1:0]  fill_col;
  logic [7:0]        fill_color;
  logic              hit;
  logic [COL_W-1:0]  hit_col;
  cell_t             hit_data;
  logic              scroll_pending;
  logic [ROW_W-1:0]  scroll_row;
  cell_t             cell_out;

  // decoded work of the held command
  logic              accept;
  logic              is_put, is_bksp, is_read, is_newline, bksp_noop;
  logic [ROW_W:0]    line_inc;
  logic              wrap_scroll;
  logic [ROW_W-1:0]  adv_line;
  logic [COL_W:0]    col_inc;
  logic              col_wrap;
  logic [ROW_W-1:0]  bksp_line;
  logic [COL_W-1:0]  bksp_col;
  logic [ROW_W-1:0]  wr_line;
  logic [COL_W-1:0]  wr_col;
  logic [7:0]        wr_char;
  logic [RSUM_W-1:0] read_sum;
  logic              read_ok;
  logic [ROW_W-1:0]  op_row;
  logic [COL_W-1:0]  op_col;
  logic [ROW_W-1:0]  op_phys;
  logic [ADDR_W-1:0] op_addr;
  logic              do_cell, cell_hit, do_read;
  logic [VSUM_W-1:0] top_plus_h;
  logic [ROW_W-1:0]  ring_inc;
  logic              fill_last;

  always_comb begin
    is_put     = item.command == CMD_PUT;
    is_bksp    = item.command == CMD_BKSP;
    is_read    = item.command == CMD_READ;
    is_newline = item.char_code == CH_NEWLINE;
    bksp_noop  = (cursor_x == '0) && (cursor_line == '0);

    line_inc    = {1'b0, cursor_line} + (ROW_W+1)'(1);
    wrap_scroll = line_inc >= (ROW_W+1)'(LINES);
    adv_line    = wrap_scroll ? ROW_W'(LINES - 1) : ROW_W'(line_inc);
    col_inc     = {1'b0, cursor_x} + (COL_W+1)'(1);
    col_wrap    = col_inc >= (COL_W+1)'(WIDTH);

    bksp_line = (cursor_x == '0) ? cursor_line - ROW_W'(1) : cursor_line;
    bksp_col  = (cursor_x == '0) ? COL_W'(WIDTH - 1) : cursor_x - COL_W'(1);

    wr_line = is_bksp ? bksp_line : cursor_line;
    wr_col  = is_bksp ? bksp_col : cursor_x;
    wr_char = is_bksp ? CH_SPACE : item.char_code;

    read_sum = RSUM_W'(top_line) + RSUM_W'(item.view_row);
    read_ok  = (item.view_row < HEIGHT) && (item.view_col < WIDTH) && (read_sum < LINES);

    op_row  = is_read ? ROW_W'(read_sum) : wr_line;
    op_col  = is_read ? COL_W'(item.view_col) : wr_col;
    op_phys = phys_row(ring_base, op_row);
    op_addr = row_base(op_phys) + ADDR_W'(op_col);

    do_cell  = (is_put && !is_newline) || (is_bksp && !bksp_noop);
    cell_hit = written[op_phys];
    do_read  = is_read && read_ok && cell_hit;

    top_plus_h = VSUM_W'(top_line) + VSUM_W'(HEIGHT);
    ring_inc   = (ring_base == ROW_W'(LINES - 1)) ? '0 : ring_base + ROW_W'(1);
    fill_last  = fill_col == COL_W'(WIDTH - 1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        if (do_cell && !cell_hit) begin
          state_next = ST_FILL;
        end else if (is_put && (is_newline || col_wrap) && wrap_scroll) begin
          state_next = ST_SCROLL;
        end else if (do_read) begin
          state_next = ST_READ;
        end
      end
      ST_READ:   state_next = ST_IDLE;
      ST_FILL: begin
        if (fill_last) state_next = scroll_pending ? ST_SCROLL : ST_IDLE;
      end
      ST_SCROLL: state_next = ST_FILL;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_stall = !((state == ST_IDLE) && (!pend || rsp_free));
    accept    = cmd_valid && !cmd_stall;
    done      = (state == ST_IDLE) && pend && rsp_free;

    ram_req       = '0;
    ram_req.waddr = op_addr;
    ram_req.raddr = op_addr;
    ram_req.wdata = '{ch: wr_char, color: text_color};
    case (state)
      ST_EXEC: begin
        ram_req.we = do_cell && cell_hit;
        ram_req.re = do_read;
      end
      ST_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = fill_addr;
        ram_req.wdata = (hit && fill_col == hit_col) ? hit_data
                                                     : '{ch: CH_SPACE, color: fill_color};
      end
      default: ;
    endcase

    rsp_next.cursor_screen_row = 8'(DIFF_W'(cursor_line) - DIFF_W'(top_line));
    rsp_next.cursor_column     = 7'(cursor_x);
    rsp_next.view_top          = 8'(top_line);
    rsp_next.lines_used        = 8'(total_lines);
    rsp_next.cell_char         = cell_out.ch;
    rsp_next.cell_color        = cell_out.color;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pend        <= 1'b0;
      cursor_line <= '0;
      cursor_x    <= '0;
      top_line    <= '0;
      total_lines <= '0;
      ring_base   <= '0;
      blank_color <= COLOR_DEFAULT;
      written     <= '0;
    end else begin
      state <= state_next;
      if (state != ST_IDLE && state_next == ST_IDLE) begin
        pend <= 1'b1;
      end else if (done) begin
        pend <= 1'b0;
      end

      if (state == ST_EXEC) begin
        case (item.command)
          CMD_PUT: begin
            if (!is_newline && !cell_hit) written[op_phys] <= 1'b1;
            if (is_newline || col_wrap) begin
              cursor_x    <= '0;
              cursor_line <= adv_line;
              total_lines <= LINE_W'(adv_line) + LINE_W'(1);
              if (wrap_scroll) ring_base <= ring_inc;
              // only a newline drags the view along
              if (is_newline && VSUM_W'(adv_line) >= top_plus_h) begin
                top_line <= ROW_W'(VSUM_W'(adv_line) + VSUM_W'(1) - VSUM_W'(HEIGHT));
              end
            end else begin
              cursor_x <= COL_W'(col_inc);
            end
          end
          CMD_BKSP: begin
            if (!bksp_noop) begin
              cursor_line <= bksp_line;
              cursor_x    <= bksp_col;
              if (!cell_hit) written[op_phys] <= 1'b1;
            end
          end
          CMD_UP: begin
            if (top_line != '0) top_line <= top_line - ROW_W'(1);
          end
          CMD_DOWN: begin
            if (top_plus_h < VSUM_W'(total_lines)) top_line <= top_line + ROW_W'(1);
          end
          CMD_CLEAR: begin
            written     <= '0;
            blank_color <= text_color;
            ring_base   <= '0;
            cursor_line <= '0;
            cursor_x    <= '0;
            top_line    <= '0;
            total_lines <= '0;
          end
          default: ;
        endcase
      end

      if (state == ST_SCROLL) begin
        written[scroll_row] <= 1'b1;
      end
    end
  end

  // held item, fill sweep and read data
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cmd;
    end
    case (state)
      ST_EXEC: begin
        scroll_row     <= ring_base;
        scroll_pending <= is_put && !is_newline && col_wrap && wrap_scroll;
        fill_addr      <= row_base(op_phys);
        fill_col       <= '0;
        fill_color     <= blank_color;
        hit            <= 1'b1;
        hit_col        <= wr_col;
        hit_data       <= '{ch: wr_char, color: text_color};
        if (is_read && read_ok) begin
          cell_out <= '{ch: CH_SPACE, color: blank_color};
        end else begin
          cell_out <= '0;
        end
      end
      ST_READ: begin
        cell_out <= ram_rdata;
      end
      ST_FILL: begin
        fill_addr <= fill_addr + ADDR_W'(1);
        fill_col  <= fill_col + COL_W'(1);
      end
      ST_SCROLL: begin
        fill_addr      <= row_base(scroll_row);
        fill_col       <= '0;
        fill_color     <= text_color;
        hit            <= 1'b0;
        scroll_pending <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/text_terminal_scrollback.sv
`default_nettype none

// Text terminal with a scrollback store of LINES rows by WIDTH cells, each cell a character
// and a color byte, kept in one single-port-write, registered-read cell RAM addressed through
// a ring base. One command word is taken at a time and answered by one result word that
// reports the cursor, the view and, for a read, the cell. A command on an already written row
// is taken, then executed in the RAM, and the next word is taken in the same cycle that the
// result leaves; a new word is not taken before the last one is answered. A read of a cell in
// a written row adds a read step for the registered RAM read; a read of a blank row or of a
// cell off the screen does without it. The first write into a row still blank after reset or
// clear adds a fill sweep over its WIDTH cells, and a store scroll (a newline or wrap past the
// last line) adds a scroll step and a fill sweep to blank the new last row; both are bound by
// the single RAM write port writing one cell a cycle. Clear is instant: per-row written flags
// reset at once, no clearing pass. The user is to write the text_color register through the
// cfg port only while the block is idle; the block itself does not enforce this.
module text_terminal_scrollback (
  input  logic            clk,
  input  logic            rst,
  // command words
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  ttsb_pkg::cmd_t  cmd,
  // result words
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ttsb_pkg::rsp_t  rsp,
  // text_color register
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_data
);
  import ttsb_pkg::*;

  logic [7:0] text_color;
  logic       rsp_free;
  logic       done;
  rsp_t       rsp_next;
  ram_req_t   ram_req;
  cell_t      ram_rdata;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= COLOR_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      text_color <= cfg_data;
    end
  end

  // output register parts the result side from the sequencer
  assign rsp_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= rsp_next;
    end
  end

  // cursor, view and row bookkeeping plus the fill sequencer
  ttsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .text_color(text_color),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_stall (cmd_stall),
    .rsp_free  (rsp_free),
    .done      (done),
    .rsp_next  (rsp_next),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // character and color cells
  ttsb_cell_ram u_ram (
    .clk  (clk),
    .req  (ram_req),
    .rdata(ram_rdata)
  );

`ifndef SYNTHESIS
  // one command in flight: the word after a take is always held off
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("command taken while another one is executing");

  // a result is only handed over when the output register can take it
  a_done_has_room: assert property (@(posedge clk) disable iff (rst)
    done |-> (!rsp_valid || !rsp_stall))
    else $error("result produced while the output register is full");

  // the cell ram never reads and writes in the same cycle
  a_ram_excl: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> !ram_req.re)
    else $error("cell ram read and write in the same cycle");

  // writes stay inside the store
  a_ram_range: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (ram_req.waddr < DEPTH))
    else $error("cell ram write beyond the store");
`endif

endmodule

`default_nettype wire
